FILE: hdl/stereo_linked_compander_top_assert.svh
// ----------------------------------------------------------------------------
// stereo_linked_compander_top_assert.svh
// Assertion macros for the stereo linked compander.
// ----------------------------------------------------------------------------
`ifndef STEREO_LINKED_COMPANDER_TOP_ASSERT_SVH
`define STEREO_LINKED_COMPANDER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// check a condition on every clock edge outside reset
`define SLC_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("slc assertion failed");
// check that a condition implies another in the next cycle
`define SLC_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("slc assertion failed");
`else
`define SLC_ASSERT_ALWAYS(lbl, cond)
`define SLC_ASSERT_NEXT(lbl, pre, post)
`endif

`endif

FILE: hdl/slc_pkg.sv
// ----------------------------------------------------------------------------
// slc_pkg
// Shared types, constants and table functions of the stereo linked compander.
// ----------------------------------------------------------------------------
`default_nettype none
package slc_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_THRESHOLD = 3'd0;
  localparam logic [2:0] REG_RATIO     = 3'd1;
  localparam logic [2:0] REG_ATTACK    = 3'd2;
  localparam logic [2:0] REG_RELEASE   = 3'd3;
  localparam logic [2:0] REG_MIX       = 3'd4;

  localparam logic signed [14:0] THRESHOLD_RST = -15'sd5120;
  localparam logic [16:0] RATIO_RST   = 17'd32768;
  localparam logic [23:0] ATTACK_RST  = 24'd16431303;
  localparam logic [23:0] RELEASE_RST = 24'd16773721;
  localparam logic [16:0] MIX_RST     = 17'd65536;
  localparam logic [16:0] UNITY_Q16   = 17'd65536;
  localparam logic [13:0] THR_FLOOR   = 14'd15360;

  localparam logic [24:0] DB_PER_OCT_Q16 = 25'd394566;
  localparam logic [24:0] OCT_PER_DB_Q24 = 25'd2786635;
  localparam logic [63:0] LN2_Q32        = 64'd2977044472;
  localparam logic [16:0] ZERO_ENV_ATT   = 17'd65536;
  localparam logic [16:0] GAIN_FLOOR_ATT = 17'd36864;

  // multiplier operand width on the serial side
  localparam int MUL_BW = 25;

  typedef struct packed {
    logic busy;
    logic done;
  } slc_stat_t;

  function automatic logic [63:0] div_k(input logic [63:0] v, input int k);
    logic [63:0] r;
    unique case (k)
      1:  r = v;
      2:  r = v / 2;
      3:  r = v / 3;
      4:  r = v / 4;
      5:  r = v / 5;
      6:  r = v / 6;
      7:  r = v / 7;
      8:  r = v / 8;
      9:  r = v / 9;
      10: r = v / 10;
      11: r = v / 11;
      default: r = v / 12;
    endcase
    return r;
  endfunction

  // log2(1 + i/depth) in Q0.16 by repeated squaring
  function automatic logic [15:0] log_entry(input int unsigned idx, input int unsigned ltb);
    logic [63:0] x;
    logic [15:0] r;
    x = (64'd1 << 30) + ((64'(idx) << 30) >> ltb);
    r = '0;
    for (int b = 15; b >= 0; b--) begin
      x = (x * x) >> 30;
      if (x >= (64'd1 << 31)) begin
        x = x >> 1;
        r[b] = 1'b1;
      end
    end
    return r;
  endfunction

  // 2^(-i/depth) in Q1.24 from a Taylor series of exp
  function automatic logic [24:0] alog_entry(input int unsigned idx, input int unsigned ltb);
    logic [63:0] t;
    logic [63:0] sum;
    logic [63:0] term;
    t = (64'(idx) * LN2_Q32) >> ltb;
    sum = 64'd1 << 32;
    term = 64'd1 << 32;
    for (int k = 1; k <= 12; k++) begin
      term = div_k((term * t) >> 32, k);
      if (k % 2 == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    return 25'((sum + 64'd128) >> 8);
  endfunction

endpackage
`default_nettype wire

FILE: hdl/slc_mul.sv
// ----------------------------------------------------------------------------
// slc_mul
// Bit-serial unsigned multiplier: one multiplier bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module slc_mul
  import slc_pkg::*;
#(
  parameter int AW = 24,
  parameter int BW = 25
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  input  wire logic [AW-1:0]  a,
  input  wire logic [BW-1:0]  b,
  output slc_stat_t           stat,
  output logic [AW+BW-1:0]    prod
);
  localparam int PW = AW + BW;
  localparam int CW = $clog2(BW + 1);

  logic [AW-1:0] aop;
  logic [BW-1:0] bsh;
  logic [CW-1:0] cnt;
  logic          busy;
  logic          done;
  logic [AW:0]   sum;

  assign sum = {1'b0, prod[PW-1:BW]} + (bsh[0] ? {1'b0, aop} : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        aop  <= a;
        bsh  <= b;
        prod <= '0;
        cnt  <= CW'(BW);
        busy <= 1'b1;
      end else if (busy) begin
        // add at the top, shift the partial product down
        prod <= {sum, prod[BW-1:1]};
        bsh  <= bsh >> 1;
        cnt  <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
endmodule
`default_nettype wire

FILE: hdl/slc_norm.sv
// ----------------------------------------------------------------------------
// slc_norm
// Serial normalizer: shifts a nonzero word left one bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module slc_norm
  import slc_pkg::*;
#(
  parameter int W = 24
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [W-1:0]          value,
  output slc_stat_t                  stat,
  output logic [W-1:0]               mant,
  output logic [$clog2(W)-1:0]       shift
);
  localparam int KW = $clog2(W);

  logic busy;
  logic done;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        mant  <= value;
        shift <= '0;
        busy  <= 1'b1;
      end else if (busy) begin
        if (mant[W-1]) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          mant  <= mant << 1;
          shift <= shift + KW'(1);
        end
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
endmodule
`default_nettype wire

FILE: hdl/stereo_linked_compander_top.sv
// ----------------------------------------------------------------------------
// stereo_linked_compander_top
// Stereo linked compressor and expander driven by a peak envelope.
// ----------------------------------------------------------------------------
// One stereo pair goes in, one processed pair comes out, one item at a time.
// All products run through a single bit-serial multiplier, and an item needs
// at most ten products. The serial envelope normalizer shifts out the k leading
// zeros of the envelope (k is at most SAMPLE_BITS - 1), and the serial gain
// shift moves the gain right by sh bits, where sh is at most 23. A zero
// envelope whose gain falls below the floor skips the normalizer, the dB
// product and the antilog product. The input is taken again as soon as the
// result sits in the output register.
`default_nettype none
`include "stereo_linked_compander_top_assert.svh"
module stereo_linked_compander_top
  import slc_pkg::*;
#(
  parameter int SAMPLE_BITS = 24,
  parameter int LOG_TABLE_DEPTH = 256
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic signed [SAMPLE_BITS-1:0] left_in,
  input  wire logic signed [SAMPLE_BITS-1:0] right_in,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0]      left_out,
  output logic signed [SAMPLE_BITS-1:0]      right_out,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [2:0]                    cfg_index,
  input  wire logic [23:0]                   cfg_data
);
  localparam int S   = SAMPLE_BITS;
  localparam int LTB = $clog2(LOG_TABLE_DEPTH);
  localparam int AW  = (S > 21) ? S : 21;
  localparam int BW  = MUL_BW;
  localparam int PW  = AW + BW;
  localparam int KW  = $clog2(S);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_ENV   = 4'd1;
  localparam logic [3:0] ST_NORM  = 4'd2;
  localparam logic [3:0] ST_DB    = 4'd3;
  localparam logic [3:0] ST_GSET  = 4'd4;
  localparam logic [3:0] ST_GMUL  = 4'd5;
  localparam logic [3:0] ST_LMUL  = 4'd6;
  localparam logic [3:0] ST_ROM   = 4'd7;
  localparam logic [3:0] ST_SHIFT = 4'd8;
  localparam logic [3:0] ST_WET   = 4'd9;
  localparam logic [3:0] ST_DRY   = 4'd10;
  localparam logic [3:0] ST_WMIX  = 4'd11;
  localparam logic [3:0] ST_OUT   = 4'd12;

  localparam logic [S-1:0] FULL_SCALE = S'(1) << (S - 1);

  // constant tables
  logic [15:0] log_rom  [LOG_TABLE_DEPTH];
  logic [24:0] alog_rom [LOG_TABLE_DEPTH];
  for (genvar gi = 0; gi < LOG_TABLE_DEPTH; gi++) begin : g_rom
    assign log_rom[gi]  = log_entry(gi, LTB);
    assign alog_rom[gi] = alog_entry(gi, LTB);
  end

  // configuration
  logic signed [14:0] thr_reg;
  logic [16:0]        ratio_reg;
  logic [23:0]        attack_reg;
  logic [23:0]        release_reg;
  logic [16:0]        mix_reg;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr_reg     <= THRESHOLD_RST;
      ratio_reg   <= RATIO_RST;
      attack_reg  <= ATTACK_RST;
      release_reg <= RELEASE_RST;
      mix_reg     <= MIX_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_THRESHOLD: thr_reg     <= cfg_data[14:0];
        REG_RATIO:     ratio_reg   <= cfg_data[16:0];
        REG_ATTACK:    attack_reg  <= cfg_data;
        REG_RELEASE:   release_reg <= cfg_data;
        REG_MIX:       mix_reg     <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  logic [13:0] thr_mag;
  logic [16:0] fac;
  logic [16:0] mix;
  logic [16:0] dry_w;

  always_comb begin
    priority if (thr_reg > 15'sd0) begin
      thr_mag = '0;
    end else if (thr_reg < -15'sd15360) begin
      thr_mag = THR_FLOOR;
    end else begin
      thr_mag = 14'(-thr_reg);
    end
    fac   = (ratio_reg > UNITY_Q16) ? UNITY_Q16 : ratio_reg;
    mix   = (mix_reg > UNITY_Q16) ? UNITY_Q16 : mix_reg;
    dry_w = UNITY_Q16 - mix;
  end

  // shared units
  logic          mul_start;
  logic [AW-1:0] mul_a;
  logic [BW-1:0] mul_b;
  slc_stat_t     mul_stat;
  logic [PW-1:0] prod;

  slc_mul #(.AW(AW), .BW(BW)) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .stat  (mul_stat),
    .prod  (prod)
  );

  logic          norm_start;
  slc_stat_t     norm_stat;
  logic [S-1:0]  norm_mant;
  logic [KW-1:0] norm_shift;
  logic [S-1:0]  env;

  slc_norm #(.W(S)) u_norm (
    .clk   (clk),
    .rst   (rst),
    .start (norm_start),
    .value (env),
    .stat  (norm_stat),
    .mant  (norm_mant),
    .shift (norm_shift)
  );

  // datapath registers
  logic [3:0]     state;
  logic [S-1:0]   xl_mag;
  logic [S-1:0]   xr_mag;
  logic           xl_neg;
  logic           xr_neg;
  logic [S-1:0]   peak;
  logic           rising;
  logic [16:0]    att_db;
  logic           below;
  logic [20:0]    l2;
  logic [24:0]    gain;
  logic [4:0]     shcnt;
  logic           ch;
  logic [S-1:0]   wet;
  logic [PW-1:0]  dry_prod;
  logic [S-1:0]   res_l;
  logic [S-1:0]   res_r;

  // input magnitudes and peak
  logic [S-1:0] l_abs;
  logic [S-1:0] r_abs;
  logic [S-1:0] pk;
  logic         pk_rise;
  logic [S-1:0] dmag;

  always_comb begin
    l_abs   = left_in[S-1] ? S'(-left_in) : left_in;
    r_abs   = right_in[S-1] ? S'(-right_in) : right_in;
    pk      = (l_abs > r_abs) ? l_abs : r_abs;
    pk_rise = pk > env;
    dmag    = pk_rise ? (pk - env) : (env - pk);
  end

  // rounded views of the product
  logic [PW:0]    prod_x;
  logic [PW:0]    rnd24;
  logic [PW:0]    rnd16;
  logic [PW:0]    rnd17;
  logic [PW:0]    rnd15;
  logic [S-1:0]   env_new;
  logic [20:0]    att_lin;
  logic [16:0]    gdiff;
  logic [16:0]    gatt;
  logic [PW:0]    mix_sum;
  logic [S-1:0]   o_mag;
  logic           o_neg;
  logic [S-1:0]   o_res;
  logic [S-1:0]   x_cur;

  always_comb begin
    prod_x  = {1'b0, prod};
    rnd24   = prod_x + (PW+1)'(24'h800000);
    rnd16   = prod_x + (PW+1)'(16'h8000);
    rnd17   = prod_x + (PW+1)'(17'h10000);
    env_new = rising ? (peak - rnd24[24 +: S]) : (peak + rnd24[24 +: S]);
    att_lin = {norm_shift, 16'd0} - {5'd0, log_rom[norm_mant[S-2 -: LTB]]};
    gdiff   = below ? (att_db - {3'd0, thr_mag}) : ({3'd0, thr_mag} - att_db);
    gatt    = below ? rnd16[16 +: 17] : rnd17[17 +: 17];
    mix_sum = {1'b0, dry_prod} + prod_x;
    rnd15   = mix_sum + (PW+1)'(16'h8000);
    o_mag   = rnd15[16 +: S];
    o_neg   = ch ? xr_neg : xl_neg;
    x_cur   = ch ? xr_mag : xl_mag;
    if (o_neg) begin
      o_res = S'(-o_mag);
    end else if (o_mag >= FULL_SCALE) begin
      o_res = FULL_SCALE - S'(1);
    end else begin
      o_res = o_mag;
    end
  end

  assign in_stall = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      env        <= '0;
      out_valid  <= 1'b0;
      mul_start  <= 1'b0;
      norm_start <= 1'b0;
    end else begin
      mul_start  <= 1'b0;
      norm_start <= 1'b0;
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            xl_mag    <= l_abs;
            xr_mag    <= r_abs;
            xl_neg    <= left_in[S-1];
            xr_neg    <= right_in[S-1];
            peak      <= pk;
            rising    <= pk_rise;
            mul_a     <= AW'(dmag);
            mul_b     <= BW'(pk_rise ? attack_reg : release_reg);
            mul_start <= 1'b1;
            state     <= ST_ENV;
          end
        end
        ST_ENV: begin
          if (mul_stat.done) begin
            env <= env_new;
            if (env_new == '0) begin
              att_db <= ZERO_ENV_ATT;
              state  <= ST_GSET;
            end else begin
              norm_start <= 1'b1;
              state      <= ST_NORM;
            end
          end
        end
        ST_NORM: begin
          if (norm_stat.done) begin
            mul_a     <= AW'(att_lin);
            mul_b     <= DB_PER_OCT_Q16;
            mul_start <= 1'b1;
            state     <= ST_DB;
          end
        end
        ST_DB: begin
          if (mul_stat.done) begin
            att_db <= rnd24[24 +: 17];
            state  <= ST_GSET;
          end
        end
        ST_GSET: begin
          below <= att_db > {3'd0, thr_mag};
          state <= ST_GMUL;
        end
        ST_GMUL: begin
          if (!mul_stat.busy && !mul_stat.done && !mul_start) begin
            mul_a     <= AW'(gdiff);
            mul_b     <= BW'(fac);
            mul_start <= 1'b1;
          end else if (mul_stat.done) begin
            if (gatt > GAIN_FLOOR_ATT) begin
              gain  <= '0;
              shcnt <= '0;
              ch    <= 1'b0;
              state <= ST_SHIFT;
            end else begin
              mul_a     <= AW'(gatt);
              mul_b     <= OCT_PER_DB_Q24;
              mul_start <= 1'b1;
              state     <= ST_LMUL;
            end
          end
        end
        ST_LMUL: begin
          if (mul_stat.done) begin
            l2    <= rnd16[16 +: 21];
            state <= ST_ROM;
          end
        end
        ST_ROM: begin
          // fetch the antilog entry; the shifter then scales it
          gain  <= alog_rom[l2[15 -: LTB]];
          shcnt <= l2[20:16];
          ch    <= 1'b0;
          state <= ST_SHIFT;
        end
        ST_SHIFT: begin
          if (shcnt == 5'd0) begin
            mul_a     <= AW'(xl_mag);
            mul_b     <= gain;
            mul_start <= 1'b1;
            state     <= ST_WET;
          end else begin
            gain  <= gain >> 1;
            shcnt <= shcnt - 5'd1;
          end
        end
        ST_WET: begin
          if (mul_stat.done) begin
            wet       <= rnd24[24 +: S];
            mul_a     <= AW'(x_cur);
            mul_b     <= BW'(dry_w);
            mul_start <= 1'b1;
            state     <= ST_DRY;
          end
        end
        ST_DRY: begin
          if (mul_stat.done) begin
            dry_prod  <= prod;
            mul_a     <= AW'(wet);
            mul_b     <= BW'(mix);
            mul_start <= 1'b1;
            state     <= ST_WMIX;
          end
        end
        ST_WMIX: begin
          if (mul_stat.done) begin
            if (!ch) begin
              res_l     <= o_res;
              ch        <= 1'b1;
              mul_a     <= AW'(xr_mag);
              mul_b     <= gain;
              mul_start <= 1'b1;
              state     <= ST_WET;
            end else begin
              res_r <= o_res;
              state <= ST_OUT;
            end
          end
        end
        ST_OUT: begin
          // hold both channels until the previous pair has transferred
          if (!out_valid || !out_stall) begin
            left_out  <= res_l;
            right_out <= res_r;
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `SLC_ASSERT_ALWAYS(a_env_range, env <= FULL_SCALE)
  `SLC_ASSERT_ALWAYS(a_mul_idle_start, !(mul_start && mul_stat.busy))
  `SLC_ASSERT_NEXT(a_out_load, (state == ST_OUT) && !(out_valid && out_stall),
                   out_valid && (state == ST_IDLE) && (left_out == res_l))
  `SLC_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
                   out_valid && $stable(left_out) && $stable(right_out))
endmodule
`default_nettype wire
